### hw/rtl/sha_pkg.sv
// ----------------------------------------------------------------------------
// sha_pkg
// Shared constants, constant lookup functions and round control type for the SHA-256 byte stream hasher.
// ----------------------------------------------------------------------------
`default_nettype none
package sha_pkg;

	localparam int unsigned WordW = 32;

	typedef logic [WordW-1:0] word_t;

	// initial hash values
	function automatic word_t init_hash(input logic [2:0] idx);
		word_t r;
		case (idx)
			3'd0: r = 32'h6a09e667;
			3'd1: r = 32'hbb67ae85;
			3'd2: r = 32'h3c6ef372;
			3'd3: r = 32'ha54ff53a;
			3'd4: r = 32'h510e527f;
			3'd5: r = 32'h9b05688c;
			3'd6: r = 32'h1f83d9ab;
			default: r = 32'h5be0cd19;
		endcase
		return r;
	endfunction

	// round constants
	function automatic word_t round_k(input logic [5:0] t);
		word_t r;
		case (t)
			6'd0: r = 32'h428A2F98; 6'd1: r = 32'h71374491;
			6'd2: r = 32'hB5C0FBCF; 6'd3: r = 32'hE9B5DBA5;
			6'd4: r = 32'h3956C25B; 6'd5: r = 32'h59F111F1;
			6'd6: r = 32'h923F82A4; 6'd7: r = 32'hAB1C5ED5;
			6'd8: r = 32'hD807AA98; 6'd9: r = 32'h12835B01;
			6'd10: r = 32'h243185BE; 6'd11: r = 32'h550C7DC3;
			6'd12: r = 32'h72BE5D74; 6'd13: r = 32'h80DEB1FE;
			6'd14: r = 32'h9BDC06A7; 6'd15: r = 32'hC19BF174;
			6'd16: r = 32'hE49B69C1; 6'd17: r = 32'hEFBE4786;
			6'd18: r = 32'h0FC19DC6; 6'd19: r = 32'h240CA1CC;
			6'd20: r = 32'h2DE92C6F; 6'd21: r = 32'h4A7484AA;
			6'd22: r = 32'h5CB0A9DC; 6'd23: r = 32'h76F988DA;
			6'd24: r = 32'h983E5152; 6'd25: r = 32'hA831C66D;
			6'd26: r = 32'hB00327C8; 6'd27: r = 32'hBF597FC7;
			6'd28: r = 32'hC6E00BF3; 6'd29: r = 32'hD5A79147;
			6'd30: r = 32'h06CA6351; 6'd31: r = 32'h14292967;
			6'd32: r = 32'h27B70A85; 6'd33: r = 32'h2E1B2138;
			6'd34: r = 32'h4D2C6DFC; 6'd35: r = 32'h53380D13;
			6'd36: r = 32'h650A7354; 6'd37: r = 32'h766A0ABB;
			6'd38: r = 32'h81C2C92E; 6'd39: r = 32'h92722C85;
			6'd40: r = 32'hA2BFE8A1; 6'd41: r = 32'hA81A664B;
			6'd42: r = 32'hC24B8B70; 6'd43: r = 32'hC76C51A3;
			6'd44: r = 32'hD192E819; 6'd45: r = 32'hD6990624;
			6'd46: r = 32'hF40E3585; 6'd47: r = 32'h106AA070;
			6'd48: r = 32'h19A4C116; 6'd49: r = 32'h1E376C08;
			6'd50: r = 32'h2748774C; 6'd51: r = 32'h34B0BCB5;
			6'd52: r = 32'h391C0CB3; 6'd53: r = 32'h4ED8AA4A;
			6'd54: r = 32'h5B9CCA4F; 6'd55: r = 32'h682E6FF3;
			6'd56: r = 32'h748F82EE; 6'd57: r = 32'h78A5636F;
			6'd58: r = 32'h84C87814; 6'd59: r = 32'h8CC70208;
			6'd60: r = 32'h90BEFFFA; 6'd61: r = 32'hA4506CEB;
			6'd62: r = 32'hBEF9A3F7;
			default: r = 32'hC67178F2;
		endcase
		return r;
	endfunction

	// round control from the sequencer to the round unit
	typedef struct packed {
		logic       load;   // copy hash words into working vars
		logic       round;  // run one round
		logic [5:0] t;      // round index
	} rnd_ctrl_t;

endpackage
`default_nettype wire

### hw/rtl/sha_round.sv
// ----------------------------------------------------------------------------
// sha_round
// Shared round unit: working variables, rolling schedule window, one round
// per cycle while ctrl.round is set.
// ----------------------------------------------------------------------------
`default_nettype none
module sha_round (
	input  wire logic               clk,
	input  wire sha_pkg::rnd_ctrl_t ctrl,
	input  wire sha_pkg::word_t     hash [8],
	input  wire logic               wr_en,
	input  wire logic [3:0]         wr_idx,
	input  wire sha_pkg::word_t     wr_data,
	output sha_pkg::word_t          vars [8]
);

	sha_pkg::word_t win_q [16];
	sha_pkg::word_t v_q [8];
	sha_pkg::word_t wt, s0, s1, bs0, bs1, ch, maj, t1, t2, x15, x2;
	logic [3:0] ti;

	// schedule word and round terms for this round
	always_comb begin
		ti  = ctrl.t[3:0];
		x15 = win_q[ti + 4'd1];
		x2  = win_q[ti + 4'd14];
		s0  = {x15[6:0], x15[31:7]} ^ {x15[17:0], x15[31:18]} ^ (x15 >> 3);
		s1  = {x2[16:0], x2[31:17]} ^ {x2[18:0], x2[31:19]} ^ (x2 >> 10);
		if (ctrl.t < 6'd16)
			wt = win_q[ti];
		else
			wt = win_q[ti] + s0 + win_q[ti + 4'd9] + s1;
		bs1 = {v_q[4][5:0], v_q[4][31:6]} ^ {v_q[4][10:0], v_q[4][31:11]}
			^ {v_q[4][24:0], v_q[4][31:25]};
		ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		t1  = v_q[7] + bs1 + ch + sha_pkg::round_k(ctrl.t) + wt;
		bs0 = {v_q[0][1:0], v_q[0][31:2]} ^ {v_q[0][12:0], v_q[0][31:13]}
			^ {v_q[0][21:0], v_q[0][31:22]};
		maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t2  = bs0 + maj;
	end

	// window write: byte packing or schedule update
	always_ff @(posedge clk) begin
		if (wr_en)
			win_q[wr_idx] <= wr_data;
		else if (ctrl.round)
			win_q[ti] <= wt;
	end

	// working variables
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			v_q <= hash;
		end else if (ctrl.round) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	assign vars = v_q;

endmodule
`default_nettype wire

### hw/rtl/sha256_byte_stream_hash.sv
// ----------------------------------------------------------------------------
// sha256_byte_stream_hash
// SHA-256 over a byte stream with built-in padding and digest readout.
// ----------------------------------------------------------------------------
//  channel | signals                              | direction
//  in      | valid, stall, data_byte, has_byte,last| sink
//  out     | out_valid, out_stall, digest_word,   | source
//          | word_index, last_word                |
//
// Bytes are accepted while idle; the 64th byte of a block starts a load, the 64
// rounds of the shared round unit and then a hash update.
// A last item adds one or two padded blocks, then eight digest transfers.
// Out stall holds the digest readout; in stall is high while busy.
// Reset clears hash words to initial values and the byte count to zero.
`default_nettype none
module sha256_byte_stream_hash (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        valid,
	output logic             stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        has_byte,
	input  wire logic        last,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      digest_word,
	output logic [2:0]       word_index,
	output logic             last_word
);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_PAD   = 7'b0000010,
		S_LOAD  = 7'b0000100,
		S_ROUND = 7'b0001000,
		S_UPD   = 7'b0010000,
		S_LEN   = 7'b0100000,
		S_OUT   = 7'b1000000
	} state_t;

	state_t           state_q;
	sha_pkg::word_t   hash_q [8];
	sha_pkg::word_t   vars [8];
	logic [60:0]      count_q;
	logic [5:0]       rnd_q;
	logic [1:0]       phase_q;  // 0 data block, 1 pad block then len, 2 final
	logic             fin_q;    // last seen, padding pending
	logic [3:0]       pidx_q;   // pad word sweep
	logic [2:0]       oidx_q;
	logic [31:0]      cur_q;    // word being packed
	sha_pkg::rnd_ctrl_t ctrl;
	logic             wr_en;
	logic [3:0]       wr_idx;
	sha_pkg::word_t   wr_data;
	logic             acc, has_acc;
	logic [5:0]       pos;
	logic [31:0]      packed_w;
	logic [63:0]      bits;

	assign acc = valid && !stall;
	assign has_acc = acc && has_byte;
	assign stall = (state_q != S_IDLE);
	assign pos = count_q[5:0];
	assign bits = {count_q, 3'b000};

	// packed word with the new byte in its lane
	always_comb begin
		packed_w = cur_q;
		case (pos[1:0])
			2'd0: packed_w = {data_byte, 24'h0};
			2'd1: packed_w[23:16] = data_byte;
			2'd2: packed_w[15:8] = data_byte;
			default: packed_w[7:0] = data_byte;
		endcase
	end

	// window writes and round control
	always_comb begin
		wr_en   = 1'b0;
		wr_idx  = pos[5:2];
		wr_data = packed_w;
		ctrl.load  = (state_q == S_LOAD);
		ctrl.round = (state_q == S_ROUND);
		ctrl.t     = rnd_q;
		case (state_q)
			S_IDLE: begin
				wr_en = has_acc;
			end
			S_PAD: begin
				wr_en  = 1'b1;
				wr_idx = pidx_q;
				if (pidx_q == pos[5:2]) begin
					case (pos[1:0])
						2'd0: wr_data = 32'h80000000;
						2'd1: wr_data = {cur_q[31:24], 24'h800000};
						2'd2: wr_data = {cur_q[31:16], 16'h8000};
						default: wr_data = {cur_q[31:8], 8'h80};
					endcase
				end else if (pidx_q < pos[5:2]) begin
					wr_en = 1'b0;
				end else begin
					wr_data = '0;
				end
			end
			S_LEN: begin
				wr_en = 1'b1;
				if (pidx_q == 4'd14) begin
					wr_idx = 4'd14;
					wr_data = bits[63:32];
				end else if (pidx_q == 4'd15) begin
					wr_idx = 4'd15;
					wr_data = bits[31:0];
				end else begin
					wr_idx = pidx_q;
					wr_data = '0;
				end
			end
			default: ;
		endcase
	end

	sha_round u_round (
		.clk(clk), .ctrl(ctrl), .hash(hash_q), .wr_en(wr_en),
		.wr_idx(wr_idx), .wr_data(wr_data), .vars(vars)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			rnd_q   <= '0;
			phase_q <= '0;
			fin_q   <= 1'b0;
			pidx_q  <= '0;
			oidx_q  <= '0;
			cur_q   <= '0;
			for (int i = 0; i < 8; i++)
				hash_q[i] <= sha_pkg::init_hash(3'(i));
		end else begin
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						if (has_byte) begin
							count_q <= count_q + 61'd1;
							cur_q   <= packed_w;
						end
						fin_q  <= last;
						pidx_q <= '0;
						if (has_byte && pos == 6'd63) begin
							phase_q <= 2'd0;
							state_q <= S_LOAD;
						end else if (last) begin
							state_q <= S_PAD;
						end
					end
				end
				S_PAD: begin
					if (pidx_q == 4'd15) begin
						if (pos > 6'd55) begin
							pidx_q  <= '0;
							phase_q <= 2'd1;
							state_q <= S_LOAD;
						end else begin
							state_q <= S_LEN;
							pidx_q  <= 4'd14;
						end
					end else begin
						pidx_q <= pidx_q + 4'd1;
					end
				end
				S_LEN: begin
					pidx_q <= pidx_q + 4'd1;
					if (pidx_q == 4'd15) begin
						phase_q <= 2'd2;
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					rnd_q   <= '0;
					state_q <= S_ROUND;
				end
				S_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63)
						state_q <= S_UPD;
				end
				S_UPD: begin
					for (int i = 0; i < 8; i++)
						hash_q[i] <= hash_q[i] + vars[i];
					pidx_q <= '0;
					case (phase_q)
						2'd1: state_q <= S_LEN;
						2'd2: begin
							oidx_q  <= '0;
							state_q <= S_OUT;
						end
						default: state_q <= fin_q ? S_PAD : S_IDLE;
					endcase
				end
				S_OUT: begin
					if (!out_stall) begin
						oidx_q <= oidx_q + 3'd1;
						if (oidx_q == 3'd7) begin
							for (int i = 0; i < 8; i++)
								hash_q[i] <= sha_pkg::init_hash(3'(i));
							count_q <= '0;
							fin_q   <= 1'b0;
							phase_q <= '0;
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// digest readout
	assign out_valid   = (state_q == S_OUT);
	assign digest_word = hash_q[oidx_q];
	assign word_index  = oidx_q;
	assign last_word   = (oidx_q == 3'd7);

endmodule
`default_nettype wire
